/* rtl/fifo_page_replacement_core_macros.svh */
// Assertion macros shared by the page replacement checker.
`ifndef FIFO_PAGE_REPLACEMENT_CORE_MACROS_SVH
`define FIFO_PAGE_REPLACEMENT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FPR_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FPR_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fpr_pkg.sv */
// Constants, types and the frame memory request struct for the page replacement core.
package fpr_pkg;

    localparam int FRAMES     = 16;
    localparam int PAGE_BITS  = 16;
    localparam int SLOT_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W      = $clog2(FRAMES + 1);
    localparam int CFG_W      = 5;
    localparam int PAGE_IN_W  = 16;
    localparam int EVICT_W    = 16;
    localparam int SLOT_OUT_W = 4;
    localparam int FAULT_W    = 32;

    localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;
    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

    typedef logic [PAGE_BITS-1:0] page_t;
    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    typedef struct packed {
        logic  we;
        slot_t waddr;
        page_t wdata;
        slot_t raddr;
    } ram_req_t;

endpackage

/* rtl/fpr_if.sv */
// Valid/ready channels for page references and replacement results.
interface fpr_page_if;
    logic        valid;
    logic        ready;
    logic [15:0] page_id;

    modport source (output valid, output page_id, input ready);
    modport sink (input valid, input page_id, output ready);
endinterface

interface fpr_result_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic        evicted_valid;
    logic [15:0] evicted_page;
    logic [3:0]  frame_slot;
    logic [31:0] fault_count;

    modport source (output valid, output hit, output evicted_valid, output evicted_page,
                    output frame_slot, output fault_count, input ready);
    modport sink (input valid, input hit, input evicted_valid, input evicted_page,
                  input frame_slot, input fault_count, output ready);
endinterface

/* rtl/fpr_frame_ram.sv */
// Frame page store: one write port, one registered read port.
module fpr_frame_ram (
    input  logic              clk,
    input  fpr_pkg::ram_req_t req,
    output fpr_pkg::page_t    rd_data
);

    fpr_pkg::page_t mem [fpr_pkg::FRAMES];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data <= mem[req.raddr];
    end

endmodule

/* rtl/fifo_page_replacement_core.sv */
// FIFO page replacement core: sequencer around a frame store and one page comparator.
//
// Each page reference word is checked against the filled frames one frame per
// cycle through the single read port of the frame store and one comparator;
// the lowest matching frame is a hit. On a miss the page fills the next free
// frame, or, once every managed frame is full, replaces the oldest frame in
// round-robin order and reports the page that was there. Every miss adds one
// to a 32-bit fault total that saturates. frames_in_use (cfg_wdata, written
// with cfg_we; the user must write it only while idle, and the block does not
// enforce this) selects how many frames are managed; 0 acts as 1 and values
// above the frame count act as the frame count. The block takes one reference
// at a time: it is ready again after accept, a scan that stops early on a hit,
// then a fill for a miss into a free frame, or, for a replacement, subtractions
// that bring the replacement pointer below a lowered frame count, a victim read
// and the page write, then the hand-over of the result word to the output
// register, which waits while that register holds an untaken word. For a full
// 16-frame miss with replacement, the scan through the read port takes longest.
// A new reference is taken while the output register holds the last result.
module fifo_page_replacement_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fpr_pkg::CFG_W-1:0]       cfg_wdata,
    fpr_page_if.sink                        access,
    fpr_result_if.source                    result
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_FILL = 3'd2;
    localparam logic [2:0] ST_MOD  = 3'd3;
    localparam logic [2:0] ST_EVWR = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    // Control state
    logic [2:0]                   state_reg, state_next;
    logic [fpr_pkg::CFG_W-1:0]    cfg_reg, cfg_next;
    fpr_pkg::cnt_t                filled_reg, filled_next;
    fpr_pkg::slot_t               oldest_reg, oldest_next;
    logic [fpr_pkg::FAULT_W-1:0]  miss_reg, miss_next;
    fpr_pkg::cnt_t                idx_reg, idx_next;
    logic                         cmp_vld_reg, cmp_vld_next;
    logic                         out_valid_reg, out_valid_next;

    // Per-reference working values
    fpr_pkg::page_t               page_reg, page_next;
    fpr_pkg::cnt_t                limit_reg, limit_next;
    fpr_pkg::cnt_t                scan_reg, scan_next;
    fpr_pkg::slot_t               cmp_idx_reg, cmp_idx_next;
    fpr_pkg::slot_t               slot_reg, slot_next;
    logic                         hit_res_reg, hit_res_next;
    logic                         ev_res_reg, ev_res_next;
    fpr_pkg::page_t               ev_page_res_reg, ev_page_res_next;

    // Output word register
    logic                         out_hit_reg, out_hit_next;
    logic                         out_ev_reg, out_ev_next;
    logic [fpr_pkg::EVICT_W-1:0]  out_ev_page_reg, out_ev_page_next;
    logic [fpr_pkg::SLOT_OUT_W-1:0] out_slot_reg, out_slot_next;
    logic [fpr_pkg::FAULT_W-1:0]  out_fault_reg, out_fault_next;

    fpr_pkg::ram_req_t            ram_req;
    fpr_pkg::page_t               rd_data;

    fpr_pkg::cnt_t                acc_limit;
    fpr_pkg::cnt_t                acc_scan;
    logic                         match;
    logic                         scan_last;
    logic                         accept;

    fpr_frame_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    assign access.ready         = (state_reg == ST_IDLE);
    assign accept               = access.valid && access.ready;

    assign result.valid         = out_valid_reg;
    assign result.hit           = out_hit_reg;
    assign result.evicted_valid = out_ev_reg;
    assign result.evicted_page  = out_ev_page_reg;
    assign result.frame_slot    = out_slot_reg;
    assign result.fault_count   = out_fault_reg;

    // Clamp the frame count into 1..FRAMES and bound the scan by what is filled.
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            acc_limit = fpr_pkg::cnt_t'(1);
        end
        else if (fpr_pkg::CNT_W'(cfg_reg) > fpr_pkg::cnt_t'(fpr_pkg::FRAMES))
        begin
            acc_limit = fpr_pkg::cnt_t'(fpr_pkg::FRAMES);
        end
        else
        begin
            acc_limit = fpr_pkg::cnt_t'(cfg_reg);
        end
        acc_scan = (filled_reg < acc_limit) ? filled_reg : acc_limit;
    end

    // The shared comparator looks at the word read in the previous cycle.
    assign match     = cmp_vld_reg && (rd_data == page_reg);
    assign scan_last = cmp_vld_reg ? ((fpr_pkg::cnt_t'(cmp_idx_reg) + fpr_pkg::cnt_t'(1))
                                      == scan_reg)
                                   : (scan_reg == '0);

    always_comb
    begin
        state_next       = state_reg;
        cfg_next         = cfg_we ? cfg_wdata : cfg_reg;
        filled_next      = filled_reg;
        oldest_next      = oldest_reg;
        miss_next        = miss_reg;
        idx_next         = idx_reg;
        cmp_vld_next     = cmp_vld_reg;
        out_valid_next   = out_valid_reg;
        page_next        = page_reg;
        limit_next       = limit_reg;
        scan_next        = scan_reg;
        cmp_idx_next     = cmp_idx_reg;
        slot_next        = slot_reg;
        hit_res_next     = hit_res_reg;
        ev_res_next      = ev_res_reg;
        ev_page_res_next = ev_page_res_reg;
        out_hit_next     = out_hit_reg;
        out_ev_next      = out_ev_reg;
        out_ev_page_next = out_ev_page_reg;
        out_slot_next    = out_slot_reg;
        out_fault_next   = out_fault_reg;

        ram_req.we    = 1'b0;
        ram_req.waddr = slot_reg;
        ram_req.wdata = page_reg;
        ram_req.raddr = idx_reg[fpr_pkg::SLOT_W-1:0];

        // Drop the output word once the sink takes it.
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    page_next    = fpr_pkg::page_t'(access.page_id);
                    limit_next   = acc_limit;
                    scan_next    = acc_scan;
                    idx_next     = '0;
                    cmp_vld_next = 1'b0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    hit_res_next     = 1'b1;
                    ev_res_next      = 1'b0;
                    ev_page_res_next = '0;
                    slot_next        = cmp_idx_reg;
                    cmp_vld_next     = 1'b0;
                    state_next       = ST_DONE;
                end
                else if (scan_last)
                begin
                    cmp_vld_next = 1'b0;
                    state_next   = ST_FILL;
                end
                else
                begin
                    // Issue the read of the next filled frame.
                    cmp_idx_next = idx_reg[fpr_pkg::SLOT_W-1:0];
                    idx_next     = idx_reg + fpr_pkg::cnt_t'(1);
                    cmp_vld_next = 1'b1;
                end
            end
            ST_FILL:
            begin
                hit_res_next     = 1'b0;
                ev_res_next      = 1'b0;
                ev_page_res_next = '0;
                if (miss_reg != fpr_pkg::FAULT_MAX)
                begin
                    miss_next = miss_reg + fpr_pkg::FAULT_W'(1);
                end
                if (filled_reg < limit_reg)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = filled_reg[fpr_pkg::SLOT_W-1:0];
                    slot_next     = filled_reg[fpr_pkg::SLOT_W-1:0];
                    filled_next   = filled_reg + fpr_pkg::cnt_t'(1);
                    state_next    = ST_DONE;
                end
                else
                begin
                    slot_next  = oldest_reg;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                // Reduce the replacement pointer below the frame count, then read the victim.
                if (fpr_pkg::cnt_t'(slot_reg) >= limit_reg)
                begin
                    slot_next = slot_reg - limit_reg[fpr_pkg::SLOT_W-1:0];
                end
                else
                begin
                    ram_req.raddr = slot_reg;
                    state_next    = ST_EVWR;
                end
            end
            ST_EVWR:
            begin
                ev_res_next      = 1'b1;
                ev_page_res_next = rd_data;
                ram_req.we       = 1'b1;
                ram_req.waddr    = slot_reg;
                if ((fpr_pkg::cnt_t'(slot_reg) + fpr_pkg::cnt_t'(1)) == limit_reg)
                begin
                    oldest_next = '0;
                end
                else
                begin
                    oldest_next = slot_reg + fpr_pkg::slot_t'(1);
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_hit_next     = hit_res_reg;
                    out_ev_next      = ev_res_reg;
                    out_ev_page_next = fpr_pkg::EVICT_W'(ev_page_res_reg);
                    out_slot_next    = fpr_pkg::SLOT_OUT_W'(slot_reg);
                    out_fault_next   = miss_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cfg_reg       <= fpr_pkg::CFG_RESET;
            filled_reg    <= '0;
            oldest_reg    <= '0;
            miss_reg      <= '0;
            idx_reg       <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cfg_reg       <= cfg_next;
            filled_reg    <= filled_next;
            oldest_reg    <= oldest_next;
            miss_reg      <= miss_next;
            idx_reg       <= idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg        <= page_next;
        limit_reg       <= limit_next;
        scan_reg        <= scan_next;
        cmp_idx_reg     <= cmp_idx_next;
        slot_reg        <= slot_next;
        hit_res_reg     <= hit_res_next;
        ev_res_reg      <= ev_res_next;
        ev_page_res_reg <= ev_page_res_next;
        out_hit_reg     <= out_hit_next;
        out_ev_reg      <= out_ev_next;
        out_ev_page_reg <= out_ev_page_next;
        out_slot_reg    <= out_slot_next;
        out_fault_reg   <= out_fault_next;
    end

endmodule

/* rtl/fpr_checker.sv */
// Port-level checker for the page replacement core and its bind.
`include "fifo_page_replacement_core_macros.svh"

module fpr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_hit,
    input logic        out_ev_valid,
    input logic [15:0] out_ev_page,
    input logic [3:0]  out_slot,
    input logic [31:0] out_fault
);

    logic [31:0] last_fault_reg;

    // Track the fault total of the last word taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_fault_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            last_fault_reg <= out_fault;
        end
    end

    `FPR_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "ready did not drop after a reference was taken")

    `FPR_ASSERT_IMP(a_hit_keeps_faults, clk, rst_n, out_valid && out_hit, (out_fault == last_fault_reg) && !out_ev_valid, "hit changed the fault total or evicted")

    `FPR_ASSERT_IMP(a_miss_adds_fault, clk, rst_n, out_valid && !out_hit, (out_fault == last_fault_reg + 32'd1) || ((last_fault_reg == 32'hFFFF_FFFF) && (out_fault == 32'hFFFF_FFFF)), "miss did not add one fault")

    `FPR_ASSERT_NXT(a_result_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_hit) && $stable(out_ev_valid) && $stable(out_ev_page) && $stable(out_slot) && $stable(out_fault), "stalled result word changed")

endmodule

bind fifo_page_replacement_core fpr_checker u_fpr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (access.valid),
    .in_ready     (access.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_hit      (result.hit),
    .out_ev_valid (result.evicted_valid),
    .out_ev_page  (result.evicted_page),
    .out_slot     (result.frame_slot),
    .out_fault    (result.fault_count)
);

/* tb/fpr_page_checker.sv */
// Checker for the page replacement core: predicts each result word and compares it.
`timescale 1ns / 1ps

module fpr_page_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [fpr_pkg::CFG_W-1:0] cfg_wdata,
    fpr_page_if                       page_ch,
    fpr_result_if                     result_ch,
    output int                        mismatch_count,
    output int                        outcomes_due
);

    typedef struct packed {
        logic                           hit;
        logic                           evicted_valid;
        fpr_pkg::page_t                 evicted_page;
        logic [fpr_pkg::SLOT_OUT_W-1:0] frame_slot;
        logic [fpr_pkg::FAULT_W-1:0]    fault_count;
    } outcome_t;

    // Shadow copy of the frame table and the policy state.
    fpr_pkg::page_t              held_pages [fpr_pkg::FRAMES];
    int                          frames_filled;
    int                          oldest_frame;
    logic [fpr_pkg::FAULT_W-1:0] miss_total;
    logic [fpr_pkg::CFG_W-1:0]   frames_cfg;

    outcome_t pending_outcomes [$];

    // Apply one page reference to the shadow state and return its result word.
    function automatic outcome_t place_page(input fpr_pkg::page_t pg);
        int       limit;
        int       scan;
        int       slot;
        bit       found;
        outcome_t o;
        limit = int'(frames_cfg);
        if (limit < 1) limit = 1;
        if (limit > fpr_pkg::FRAMES) limit = fpr_pkg::FRAMES;
        scan = (frames_filled < limit) ? frames_filled : limit;
        o = '0;
        found = 1'b0;
        for (int i = 0; i < scan; i++) begin
            if (!found && held_pages[i] == pg) begin
                found = 1'b1;
                o.frame_slot = fpr_pkg::SLOT_OUT_W'(i);
            end
        end
        if (found) begin
            o.hit = 1'b1;
        end
        else begin
            if (frames_filled < limit) begin
                o.frame_slot = fpr_pkg::SLOT_OUT_W'(frames_filled);
                held_pages[frames_filled] = pg;
                frames_filled++;
            end
            else begin
                slot = oldest_frame % limit;
                o.frame_slot = fpr_pkg::SLOT_OUT_W'(slot);
                o.evicted_valid = 1'b1;
                o.evicted_page = held_pages[slot];
                held_pages[slot] = pg;
                oldest_frame = (slot + 1) % limit;
            end
            if (miss_total != fpr_pkg::FAULT_MAX) miss_total++;
        end
        o.fault_count = miss_total;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                   input logic [31:0] seen_v);
        $display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t", what, want_v, seen_v,
                 $realtime);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        outcome_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < fpr_pkg::FRAMES; i++) held_pages[i] = '0;
            frames_filled = 0;
            oldest_frame = 0;
            miss_total = '0;
            frames_cfg = fpr_pkg::CFG_RESET;
            pending_outcomes.delete();
            mismatch_count = 0;
            outcomes_due <= 0;
        end
        else
        begin
            if (cfg_we) frames_cfg = cfg_wdata;
            if (page_ch.valid && page_ch.ready)
                pending_outcomes.insert(pending_outcomes.size(),
                                        place_page(page_ch.page_id));
            if (result_ch.valid && result_ch.ready)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    report_mismatch("result word with nothing outstanding", 32'd0, 32'd1);
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (result_ch.hit !== want.hit)
                        report_mismatch("hit", 32'(want.hit), 32'(result_ch.hit));
                    if (result_ch.evicted_valid !== want.evicted_valid)
                        report_mismatch("evicted_valid", 32'(want.evicted_valid),
                                        32'(result_ch.evicted_valid));
                    if (result_ch.evicted_page !== want.evicted_page)
                        report_mismatch("evicted_page", 32'(want.evicted_page),
                                        32'(result_ch.evicted_page));
                    if (result_ch.frame_slot !== want.frame_slot)
                        report_mismatch("frame_slot", 32'(want.frame_slot),
                                        32'(result_ch.frame_slot));
                    if (result_ch.fault_count !== want.fault_count)
                        report_mismatch("fault_count", want.fault_count,
                                        result_ch.fault_count);
                end
            end
            outcomes_due <= int'(pending_outcomes.size());
        end
    end

endmodule

/* tb/tb_fifo_page_replacement_core.sv */
// Testbench top for the page replacement core: stimulus, idling and the verdict.
`timescale 1ns / 1ps

module tb_fifo_page_replacement_core;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [fpr_pkg::CFG_W-1:0] cfg_wdata;
    logic                      jitter_on;
    int                        hold_left;
    int                        mismatch_count;
    int                        outcomes_due;

    fpr_page_if   page_ch ();
    fpr_result_if result_ch ();

    fifo_page_replacement_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .access    (page_ch),
        .result    (result_ch)
    );

    // The checker sits beside the block and only watches the channels.
    fpr_page_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .page_ch        (page_ch),
        .result_ch      (result_ch),
        .mismatch_count (mismatch_count),
        .outcomes_due   (outcomes_due)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b0;
        #5 clk = 1'b1;
    end

    // Result side: drop ready at random while jitter is on,
    // otherwise hold it high so the output register drains every cycle.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result_ch.ready <= 1'b0;
        end
        else if (jitter_on && $urandom_range(0, 5) == 0)
        begin
            hold_left <= $urandom_range(0, 10);
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= 1'b1;
        end
    end

    // Offer one page reference word and hold it until the block takes it.
    // While jitter is on, sometimes drop valid for a burst first so that
    // gaps land on every stage of the scan and update.
    task automatic send_page(input fpr_pkg::page_t pg);
        if (jitter_on && $urandom_range(0, 3) == 0)
        begin
            page_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        page_ch.valid   <= 1'b1;
        page_ch.page_id <= pg;
        @(posedge clk);
        while (!page_ch.ready) @(posedge clk);
    endtask

    // Write frames_in_use only once the block is idle: stop offering words,
    // let the checker count the last accepted word, then wait until
    // every outstanding result word has drained.
    task automatic set_frames(input logic [fpr_pkg::CFG_W-1:0] n);
        page_ch.valid <= 1'b0;
        @(posedge clk);
        while (outcomes_due != 0) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= n;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [fpr_pkg::CFG_W-1:0] plan [10];
        fpr_pkg::page_t            base;
        fpr_pkg::page_t            pg;
        int                        eff;
        int                        roll;

        // Known values on every input from time zero.
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = fpr_pkg::CFG_RESET;
        jitter_on         = 1'b0;
        page_ch.valid     = 1'b0;
        page_ch.page_id   = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        jitter_on <= 1'b1;

        // Four frames: fill, hit, fill to full, then replace round-robin.
        // The all-ones and all-zero pages cover every bit of the field.
        set_frames(5'd4);
        send_page(16'hFFFF);
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h1234);
        send_page(16'h8000);
        send_page(16'h0001);
        send_page(16'h0000);
        send_page(16'h5555);

        // Lower the count to two: frames above it drop out of the compare,
        // so a page still parked in frame 3 misses and lands in frame 0.
        set_frames(5'd2);
        send_page(16'h8000);
        send_page(16'h1234);

        // Raise back to four: the page is now in two frames and the hit
        // must report the lower one.
        set_frames(5'd4);
        send_page(16'h8000);
        send_page(16'h1234);

        // Zero acts as a single frame: every miss replaces frame 0.
        set_frames(5'd0);
        send_page(16'hAAAA);
        send_page(16'hAAAA);
        send_page(16'h7FFF);

        // Values above the frame count act as the frame count; filling
        // resumes where it stopped.
        set_frames(5'd31);
        send_page(16'h0002);
        send_page(16'h0004);
        send_page(16'h7FFF);

        // Random part: each phase picks a frame count (extremes included,
        // so counts go both up and down between phases) and a working set
        // a little wider than the frames, which yields a mix of hits,
        // fills and evictions. A few fully random pages add noise.
        plan = '{5'd1, 5'd16, 5'd3, 5'd31, 5'd0, 5'd8, 5'd0, 5'd2, 5'd16, 5'd5};
        plan[6] = fpr_pkg::CFG_W'($urandom_range(0, 31));
        for (int ph = 0; ph < 10; ph++)
        begin
            set_frames(plan[ph]);
            eff = int'(plan[ph]);
            if (eff < 1) eff = 1;
            if (eff > fpr_pkg::FRAMES) eff = fpr_pkg::FRAMES;
            base = fpr_pkg::page_t'($urandom);
            for (int k = 0; k < 115; k++)
            begin
                // Flip idling in stretches; the last phase runs with none.
                if (k % 40 == 0)
                    jitter_on <= (ph != 9) && ($urandom_range(0, 3) != 0);
                if (k % 30 == 29)
                    base = fpr_pkg::page_t'($urandom);
                roll = $urandom_range(0, 9);
                if (roll < 8)
                    pg = base + fpr_pkg::page_t'($urandom_range(0, eff + 2));
                else
                    pg = fpr_pkg::page_t'($urandom);
                send_page(pg);
            end
        end

        // Drain: stop offering words, wait for every result word, then
        // allow a few more cycles for any stray word to show up.
        page_ch.valid <= 1'b0;
        @(posedge clk);
        while (outcomes_due != 0) @(posedge clk);
        repeat (60) @(posedge clk);

        if (mismatch_count == 0 && outcomes_due == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: a correct run finishes well inside this bound.
    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/fpr_pkg.sv
rtl/fpr_if.sv
rtl/fpr_frame_ram.sv
rtl/fifo_page_replacement_core.sv
rtl/fpr_checker.sv
tb/fpr_page_checker.sv
tb/tb_fifo_page_replacement_core.sv
